[rtl/sfr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the serial frame receiver modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // field widths
    localparam int POS_W  = 6;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;

    // header byte value
    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;

    // highest block number that can be enabled in the accept mask
    localparam logic [BYTE_W-1:0] BLK_MAX = 8'd7;

    // register map
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [0:0] REG_ACCEPT_MASK = 1'b0;
    localparam logic [BYTE_W-1:0] ACCEPT_MASK_RST = 8'd58;

    // result status codes
    localparam logic [STAT_W-1:0] ST_HDR_OK   = 3'd0;
    localparam logic [STAT_W-1:0] ST_RESYNC   = 3'd1;
    localparam logic [STAT_W-1:0] ST_PAYLOAD  = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMIT     = 3'd3;
    localparam logic [STAT_W-1:0] ST_CK_BAD   = 3'd4;
    localparam logic [STAT_W-1:0] ST_REJECT   = 3'd5;
    localparam logic [STAT_W-1:0] ST_LINE_ERR = 3'd6;

    // input command codes
    localparam logic CMD_BYTE     = 1'b0;
    localparam logic CMD_LINE_ERR = 1'b1;

    // input request
    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] rx_byte;
    } t_rx_req;

    // result
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] frame_byte;
        logic [POS_W-1:0]  byte_position;
        logic [BYTE_W-1:0] block_number;
        logic              last;
    } t_rx_res;

endpackage
`default_nettype wire

[rtl/sfr_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// APB-style register port holding the block accept mask.
// ----------------------------------------------------------------------------
module sfr_cfg_regs
    import sfr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [BYTE_W-1:0]     o_accept_mask
);

    logic [BYTE_W-1:0] r_mask;
    logic              wr_en;
    logic              sel_mask;

    // word index decode, byte offset ignored
    assign sel_mask = (paddr[CFG_ADDR_W-1:2] == REG_ACCEPT_MASK);
    assign pready   = 1'b1;
    assign wr_en    = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= ACCEPT_MASK_RST;
        end else if (wr_en && sel_mask) begin
            r_mask <= pwdata[BYTE_W-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (sel_mask) begin
            prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, r_mask};
        end
    end

    assign o_accept_mask = r_mask;

endmodule
`default_nettype wire

[rtl/serial_frame_receiver.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Header, payload, checksum and block check of a fixed frame, with the frame kept in
// a one-port-write, one-port-read memory and replayed when accepted.
// ----------------------------------------------------------------------------
// Results: a result is registered in the cycle after each accepted request,
//   but a checksum byte that passes gives none and starts the replay instead.
// Throughput: one request per cycle while no frame is replayed and the output
//   is not stalled; a good frame replays FRAME_TOP+1 bytes, each read from the
//   memory in S_RD, then loaded into the output in S_OUT, held by output stalls.
// Reset: position set to the frame top; sum, state and output valid cleared;
//   the frame memory is not cleared, every entry is written within a frame
//   before it is read.
// ----------------------------------------------------------------------------
module serial_frame_receiver
    import sfr_pkg::*;
#(
    parameter int FRAME_TOP = 40
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input requests
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_rx_req               i_in_data,
    // results
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_rx_res                    o_out_data,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int IDX_W = $clog2(FRAME_TOP + 1);
    localparam logic [POS_W-1:0] P_TOP  = POS_W'(FRAME_TOP);
    localparam logic [POS_W-1:0] P_TOP1 = POS_W'(FRAME_TOP - 1);
    localparam logic [POS_W-1:0] P_BLK  = POS_W'(FRAME_TOP - 2);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [BYTE_W-1:0] accept_mask;

    logic [1:0]        r_state, n_state;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_blk, n_blk;
    logic [POS_W-1:0]  r_emit_pos, n_emit_pos;
    logic              r_out_valid, n_out_valid;
    t_rx_res           r_out, n_out;
    logic [BYTE_W-1:0] r_rd_data;

    logic [BYTE_W-1:0] mem [0:FRAME_TOP];

    logic              out_free;
    logic              in_acc;
    logic              emit_load;
    logic              mem_we;
    logic              blk_ok;
    logic              frame_pass;
    t_rx_res           in_res;

    sfr_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_accept_mask (accept_mask)
    );

    // handshake
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign emit_load  = (r_state == S_OUT) && out_free;
    assign mem_we     = in_acc && (i_in_data.command == CMD_BYTE);

    // block number check against the mask
    assign blk_ok = (r_blk <= BLK_MAX) && accept_mask[r_blk[2:0]];

    // frame memory: write on every received byte, read during replay
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_pos[IDX_W-1:0]] <= i_in_data.rx_byte;
        end
        if (r_state == S_RD) begin
            r_rd_data <= mem[r_emit_pos[IDX_W-1:0]];
        end
    end

    // result of one received request
    always_comb begin
        in_res               = '0;
        in_res.byte_position = r_pos;
        in_res.last          = 1'b1;
        frame_pass           = 1'b0;
        n_pos                = r_pos;
        n_sum                = r_sum;
        n_blk                = r_blk;
        if (i_in_data.command == CMD_LINE_ERR) begin
            in_res.status = ST_LINE_ERR;
            n_pos         = P_TOP;
        end else if (r_pos == P_TOP) begin
            if (i_in_data.rx_byte == HDR_BYTE) begin
                in_res.status = ST_HDR_OK;
                n_pos         = P_TOP1;
            end else begin
                in_res.status = ST_RESYNC;
            end
        end else if (r_pos == P_TOP1) begin
            if (i_in_data.rx_byte == HDR_BYTE) begin
                in_res.status = ST_HDR_OK;
                n_pos         = P_BLK;
                n_sum         = '0;
            end else begin
                in_res.status = ST_RESYNC;
                n_pos         = P_TOP;
            end
        end else if (r_pos != '0) begin
            in_res.status = ST_PAYLOAD;
            n_pos         = r_pos - POS_W'(1);
            n_sum         = r_sum + i_in_data.rx_byte;
            if (r_pos == P_BLK) begin
                n_blk = i_in_data.rx_byte;
            end
        end else begin
            // checksum byte
            n_pos               = P_TOP;
            in_res.block_number = r_blk;
            if (r_sum != i_in_data.rx_byte) begin
                in_res.status = ST_CK_BAD;
            end else if (!blk_ok) begin
                in_res.status = ST_REJECT;
            end else begin
                in_res.status = ST_EMIT;
                frame_pass    = 1'b1;
            end
        end
    end

    // sequencer and output register
    always_comb begin
        n_state     = r_state;
        n_emit_pos  = r_emit_pos;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (frame_pass) begin
                        n_state    = S_RD;
                        n_emit_pos = P_TOP;
                    end else begin
                        n_out       = in_res;
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (emit_load) begin
                    n_out.status        = ST_EMIT;
                    n_out.frame_byte    = r_rd_data;
                    n_out.byte_position = r_emit_pos;
                    n_out.block_number  = r_blk;
                    n_out.last          = (r_emit_pos == '0);
                    n_out_valid         = 1'b1;
                    if (r_emit_pos == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state    = S_RD;
                        n_emit_pos = r_emit_pos - POS_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= P_TOP;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_emit_pos  <= P_TOP;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_emit_pos  <= n_emit_pos;
            if (in_acc) begin
                r_pos <= n_pos;
                r_sum <= n_sum;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_acc) begin
            r_blk <= n_blk;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // position never leaves the frame
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= P_TOP)
        else $error("receive position beyond frame top");

    // only replayed bytes may come without the last flag
    a_last_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> (o_out_data.status == ST_EMIT))
        else $error("non-last result outside frame replay");

    // the final replayed byte carries the last flag
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_load && (r_emit_pos == '0)) |=> (o_out_valid && o_out_data.last))
        else $error("frame replay ended without last flag");

    // no new request is taken in the replay read state
    a_no_req_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> !in_acc)
        else $error("request accepted during frame replay");

endmodule
`default_nettype wire

[dv/serial_frame_receiver_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_receiver_test
// Self-checking bench for the serial frame receiver. A class keeps its own
// copy of the receiver state and the accept mask, works out the results of
// each accepted request and checks every accepted result in order. Stimulus
// is a short directed run over the header, resync and line error cases,
// then random frames (good, bad checksum, rejected block, broken) mixed with
// noise. Six accept mask settings are used. Both sides stall at random.
// ----------------------------------------------------------------------------
module serial_frame_receiver_test;
    import sfr_pkg::*;

    localparam int TOP          = 40;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int IDLE_CYCLES  = 8;
    localparam int PHASE_ITEMS  = 32;
    localparam int REPORT_LIMIT = 10;

    // ------------------------------------------------------------------------
    // Receiver prediction and result checking
    // ------------------------------------------------------------------------
    class rx_frame_checker;
        logic [BYTE_W-1:0] accept_mask;
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] payload_sum;
        logic [BYTE_W-1:0] frame_copy [0:TOP];
        t_rx_res           results_due [$];
        int                fail_count;

        function new();
            accept_mask = ACCEPT_MASK_RST;
            position    = POS_W'(TOP);
            payload_sum = '0;
            fail_count  = 0;
            foreach (frame_copy[i]) frame_copy[i] = '0;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
        endfunction

        // work out the results of one accepted request
        function void predict_request(t_rx_req req);
            t_rx_res           res;
            logic [BYTE_W-1:0] blk;
            bit                hdr_good;
            res               = '0;
            res.last          = 1'b1;
            res.byte_position = position;
            hdr_good          = (req.rx_byte == HDR_BYTE);

            if (req.command == CMD_LINE_ERR) begin
                res.status = ST_LINE_ERR;
                position   = POS_W'(TOP);
                results_due.push_back(res);
                return;
            end

            frame_copy[position] = req.rx_byte;

            if (position == POS_W'(TOP)) begin
                res.status = hdr_good ? ST_HDR_OK : ST_RESYNC;
                if (hdr_good) position = POS_W'(TOP - 1);
                results_due.push_back(res);
            end else if (position == POS_W'(TOP - 1)) begin
                res.status = hdr_good ? ST_HDR_OK : ST_RESYNC;
                if (hdr_good) begin
                    position    = POS_W'(TOP - 2);
                    payload_sum = '0;
                end else begin
                    position = POS_W'(TOP);
                end
                results_due.push_back(res);
            end else if (position != '0) begin
                res.status  = ST_PAYLOAD;
                position    = position - 1'b1;
                payload_sum = payload_sum + req.rx_byte;
                results_due.push_back(res);
            end else begin
                // checksum byte: always back to the header after it
                position         = POS_W'(TOP);
                blk              = frame_copy[TOP - 2];
                res.block_number = blk;
                if (payload_sum != req.rx_byte) begin
                    res.status = ST_CK_BAD;
                    results_due.push_back(res);
                end else if (blk > BLK_MAX || !accept_mask[blk[2:0]]) begin
                    res.status = ST_REJECT;
                    results_due.push_back(res);
                end else begin
                    for (int p = TOP; p >= 0; p--) begin
                        res.status        = ST_EMIT;
                        res.frame_byte    = frame_copy[p];
                        res.byte_position = POS_W'(p);
                        res.last          = (p == 0);
                        results_due.push_back(res);
                    end
                end
            end
        endfunction

        // compare one accepted result with the oldest one due
        function void check_result(t_rx_res got);
            t_rx_res want;
            if (results_due.size() == 0) begin
                flag($sformatf("unexpected result st=%0d byte=%02h pos=%0d blk=%02h last=%0b",
                               got.status, got.frame_byte, got.byte_position,
                               got.block_number, got.last));
                return;
            end
            want = results_due.pop_front();
            if (got.status != want.status || got.frame_byte != want.frame_byte ||
                got.byte_position != want.byte_position ||
                got.block_number != want.block_number || got.last != want.last) begin
                flag($sformatf({"expected st=%0d byte=%02h pos=%0d blk=%02h last=%0b, ",
                                "got st=%0d byte=%02h pos=%0d blk=%02h last=%0b"},
                               want.status, want.frame_byte, want.byte_position,
                               want.block_number, want.last,
                               got.status, got.frame_byte, got.byte_position,
                               got.block_number, got.last));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_rx_req               i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_rx_res               o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    rx_frame_checker checker_h;
    int              cycle_count;
    int              items_sent;
    bit              calm;
    int              out_hold;

    serial_frame_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // known values on every input from time zero
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        checker_h   = new();
        items_sent  = 0;
        calm        = 1'b0;
        out_hold    = 0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // result side back-pressure
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_ready <= 1'b0;
            out_hold    <= out_hold - 1;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) out_hold <= pick_gap();
        end
    end

    // monitor: note accepted requests, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) checker_h.predict_request(i_in_data);
            if (o_out_valid && i_out_ready) checker_h.check_result(o_out_data);
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // one request, after a random gap, held until accepted
    task automatic send_req(input logic cmd, input logic [BYTE_W-1:0] value);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid        <= 1'b1;
        i_in_data.command <= cmd;
        i_in_data.rx_byte <= value;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        send_req(CMD_BYTE, value);
    endtask

    task automatic send_line_err();
        send_req(CMD_LINE_ERR, BYTE_W'($urandom_range(0, 255)));
    endtask

    // stop sending and wait until every result has come out
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (checker_h.pending() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    // register read, low byte compared with the predicted mask
    task automatic read_mask();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_ADDR_W'(4 * REG_ACCEPT_MASK);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[BYTE_W-1:0] !== checker_h.accept_mask)
            checker_h.flag($sformatf("accept mask read expected %02h, got %02h",
                                     checker_h.accept_mask, prdata[BYTE_W-1:0]));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // register write, then read back
    task automatic write_mask(input logic [BYTE_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * REG_ACCEPT_MASK);
        pwdata  <= CFG_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        checker_h.accept_mask = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_mask();
    endtask

    // one frame: well formed with random content, or broken part way
    task automatic send_frame(input bit broken);
        logic [BYTE_W-1:0] bytes [0:TOP];
        logic [BYTE_W-1:0] sum;
        int                cut;
        int                kind;
        sum  = '0;
        kind = $urandom_range(0, 2);
        cut  = -1;
        if (broken) cut = (kind == 0) ? TOP : (kind == 1) ? TOP - 1 : $urandom_range(0, TOP);

        bytes[TOP]     = HDR_BYTE;
        bytes[TOP - 1] = HDR_BYTE;
        // block number: mostly one that the mask can enable
        if ($urandom_range(0, 9) < 7) bytes[TOP - 2] = BYTE_W'($urandom_range(0, 7));
        else if ($urandom_range(0, 3) == 0) bytes[TOP - 2] = 8'hFF;
        else bytes[TOP - 2] = BYTE_W'($urandom_range(8, 255));
        for (int p = TOP - 3; p >= 1; p--) bytes[p] = BYTE_W'($urandom_range(0, 255));
        for (int p = TOP - 2; p >= 1; p--) sum = sum + bytes[p];
        bytes[0] = ($urandom_range(0, 9) < 7) ? sum
                                              : sum + BYTE_W'($urandom_range(1, 255));

        for (int p = TOP; p >= 0; p--) begin
            if (p == cut) begin
                if (kind == 2) send_line_err();
                else send_byte(BYTE_W'($urandom_range(0, 254)));
                return;
            end
            send_byte(bytes[p]);
        end
    endtask

    // short noise burst that always leaves the receiver waiting for a header
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0: send_line_err();
                1: send_byte(BYTE_W'($urandom_range(0, 254)));
                default: begin
                    send_byte(HDR_BYTE);
                    send_byte(BYTE_W'($urandom_range(0, 254)));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [BYTE_W-1:0] masks [0:5];
        int                phase_start;
        masks[0] = ACCEPT_MASK_RST;
        masks[1] = 8'hFF;
        masks[2] = 8'h00;
        masks[3] = BYTE_W'($urandom_range(0, 255));
        masks[4] = 8'h01;
        masks[5] = 8'h80;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset value of the mask
        read_mask();

        // directed: line error, header checks, resync, line error mid-frame
        send_req(CMD_LINE_ERR, 8'hFF);
        send_byte(8'h00);                  // first header wrong
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(8'h07);                  // block number
        send_byte(8'h00);
        send_req(CMD_LINE_ERR, 8'h00);     // line error in the payload
        send_byte(HDR_BYTE);
        send_byte(8'h00);                  // second header wrong
        send_byte(HDR_BYTE);
        send_byte(8'hFE);                  // second header wrong, not rechecked
        send_byte(8'hFE);                  // now a wrong first header
        send_byte(HDR_BYTE);
        send_line_err();                   // line error on the second header
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(8'hFF);                  // out-of-range block number
        send_line_err();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                wait_idle();
                write_mask(masks[ph]);
            end
            calm        = (ph == 3);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 3) == 0) send_noise();
                else send_frame($urandom_range(0, 4) == 0);
            end
        end

        wait_idle();
        repeat (4 * (TOP + 1)) @(posedge i_clk);

        if (checker_h.fail_count == 0 && checker_h.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
